@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; each macro takes a label, a property body and a message
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/swm_pkg.sv @@
// shared constants and types of the sliding window median filter
// no dependencies; used by swm_cell, sliding_window_median and swm_checker
package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int CFG_W        = 7;
  localparam int AGE_W        = $clog2(MAX_WINDOW);
  localparam int LEN_W        = $clog2(MAX_WINDOW + 1);
  localparam int OUT_W        = SAMPLE_WIDTH + 1;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic [AGE_W-1:0]        age;
    logic [SAMPLE_WIDTH-1:0] value;
    logic                    le;    // live entry not above the new sample
    logic                    good;  // valid and not past the window length
  } cell_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    step;
    logic                    start;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [LEN_W-1:0]        len;
  } cell_ctrl_t;

  // per cell status gathered by the top level
  typedef struct packed {
    logic stale;  // entry too old for the current length
    logic gap;    // empty cell under an occupied one
    logic full;   // oldest entry of a full window after the next step
  } cell_stat_t;

  // virtual neighbor under cell 0: the new sample never goes below it
  localparam cell_out_t BELOW_TIE = '{valid: 1'b0, age: '0, value: '0, le: 1'b1, good: 1'b0};
  // virtual neighbor above the last cell: always empty
  localparam cell_out_t ABOVE_TIE = '{valid: 1'b0, age: '0, value: '0, le: 1'b0, good: 1'b0};

endpackage

@@ rtl/sliding_window_median.sv @@
// top level of the sliding window median filter: cell row, handshakes, output stage
// depends on swm_pkg and swm_cell
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  cfg      | in        | cfg_valid/cfg_ready  | window_len
//  in       | in        | in_valid/in_ready    | sample, start_new
//  out      | out       | out_valid/out_ready  | median_doubled
//
// one sample per cycle while in_ready is high; a taken sample is registered in the cell row,
// then its median passes the tap add into the output register
// after a write that shortens the window, in_ready stays low while the entries that fall
// out leave the row and the row compacts
// in_ready also drops while a result waits in the tap stage and the output holds
// synchronous reset empties the row and the output; the window length register goes back to 3
module sliding_window_median import swm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        window_len,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    start_new,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_W-1:0]        median_doubled
);

  logic [CFG_W-1:0]      win;
  logic [LEN_W-1:0]      len_eff;
  logic [LEN_W-1:0]      half;
  logic [LEN_W-1:0]      half_lo;
  logic [MAX_WINDOW-1:0] tap_a;
  logic [MAX_WINDOW-1:0] tap_b;
  logic                  pend;
  logic                  slot;
  logic                  busy;
  logic                  full_any;
  logic                  accept;
  logic                  result_gen;
  cell_ctrl_t            ctrl;

  cell_out_t               nb     [MAX_WINDOW+2];
  cell_out_t               co     [MAX_WINDOW];
  cell_stat_t              st     [MAX_WINDOW];
  logic [MAX_WINDOW:0]     drop_c;
  logic [MAX_WINDOW:0]     hole_c;
  logic [SAMPLE_WIDTH-1:0] tva    [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] tvb    [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] med_a;
  logic [SAMPLE_WIDTH-1:0] med_b;

  // window length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= CFG_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      win <= window_len;
    end
  end

  // length clamped to one through MAX_WINDOW
  always_comb begin
    if (win == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(win) > LEN_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(win);
    end
    half    = len_eff >> 1;
    half_lo = len_eff[0] ? half : half - LEN_W'(1);
  end

  // one-hot taps on the middle cells
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      tap_a[i] <= (half_lo == LEN_W'(i));
      tap_b[i] <= (half == LEN_W'(i));
    end
  end

  // status gathered from the row
  always_comb begin
    busy     = 1'b0;
    full_any = 1'b0;
    med_a    = '0;
    med_b    = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      busy     = busy | st[i].stale | st[i].gap;
      full_any = full_any | st[i].full;
      med_a    = med_a | tva[i];
      med_b    = med_b | tvb[i];
    end
  end

  // input handshake and step control
  assign slot       = ~out_valid | out_ready;
  assign in_ready   = ~busy & (~pend | slot);
  assign accept     = in_valid & in_ready;
  assign result_gen = (len_eff == LEN_W'(1)) | (~start_new & full_any);

  always_comb begin
    ctrl.step   = accept;
    ctrl.start  = start_new;
    ctrl.sample = sample;
    ctrl.len    = len_eff;
  end

  // cell row with empty virtual neighbors at both ends
  assign drop_c[0] = 1'b0;
  assign hole_c[0] = 1'b0;

  always_comb begin
    nb[0]            = BELOW_TIE;
    nb[MAX_WINDOW+1] = ABOVE_TIE;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      nb[i+1] = co[i];
    end
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    swm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .tap_a       (tap_a[g]),
      .tap_b       (tap_b[g]),
      .below       (nb[g]),
      .above       (nb[g+2]),
      .drop_in     (drop_c[g]),
      .hole_in     (hole_c[g]),
      .drop_out    (drop_c[g+1]),
      .hole_out    (hole_c[g+1]),
      .q           (co[g]),
      .stat        (st[g]),
      .tap_a_value (tva[g]),
      .tap_b_value (tvb[g])
    );
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend <= result_gen;
      end else if (pend && slot) begin
        pend <= 1'b0;
      end
      if (pend && slot) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && slot) begin
      median_doubled <= {med_a[SAMPLE_WIDTH-1], med_a} + {med_b[SAMPLE_WIDTH-1], med_b};
    end
  end

endmodule

@@ rtl/swm_cell.sv @@
// one cell of the sorted chain: holds one entry, its age and valid bit
// depends on swm_pkg; instantiated in a row by sliding_window_median
module swm_cell import swm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctrl_t              ctrl,
  input  logic                    tap_a,
  input  logic                    tap_b,
  input  cell_out_t               below,
  input  cell_out_t               above,
  input  logic                    drop_in,
  input  logic                    hole_in,
  output logic                    drop_out,
  output logic                    hole_out,
  output cell_out_t               q,
  output cell_stat_t              stat,
  output logic [SAMPLE_WIDTH-1:0] tap_a_value,
  output logic [SAMPLE_WIDTH-1:0] tap_b_value
);

  logic                    valid;
  logic [AGE_W-1:0]        age;
  logic [SAMPLE_WIDTH-1:0] value;

  logic                    valid_next;
  logic [AGE_W-1:0]        age_next;
  logic [SAMPLE_WIDTH-1:0] value_next;

  logic                    live;
  logic                    le_self;
  logic                    drop;
  logic                    stale;
  logic                    good;
  logic                    hi_le;
  logic [AGE_W-1:0]        hi_age;
  logic [SAMPLE_WIDTH-1:0] hi_value;
  logic                    lo_le;
  logic                    lo_valid;
  logic [AGE_W-1:0]        lo_age;
  logic [SAMPLE_WIDTH-1:0] lo_value;

  // own flags; a start flag empties the whole chain
  always_comb begin
    live     = valid & ~ctrl.start;
    le_self  = live && ($signed(value) <= $signed(ctrl.sample));
    drop     = live && ((LEN_W'(age) + LEN_W'(1)) >= ctrl.len);
    drop_out = drop_in | drop;
    stale    = valid && (LEN_W'(age) >= ctrl.len);
    good     = valid & ~stale;
    hole_out = hole_in | ~good;
  end

  // entries that land at this slot and the one below once the oldest leaves
  always_comb begin
    if (drop_out) begin
      hi_le    = above.le;
      hi_age   = above.age;
      hi_value = above.value;
    end else begin
      hi_le    = le_self;
      hi_age   = age;
      hi_value = value;
    end
    if (drop_in) begin
      lo_le    = le_self;
      lo_valid = live;
      lo_age   = age;
      lo_value = value;
    end else begin
      lo_le    = below.le;
      lo_valid = below.valid & ~ctrl.start;
      lo_age   = below.age;
      lo_value = below.value;
    end
  end

  // step: keep, take above, sample or below; idle: close the lowest gap
  always_comb begin
    valid_next = valid;
    age_next   = age;
    value_next = value;
    if (ctrl.step) begin
      if (hi_le) begin
        valid_next = 1'b1;
        age_next   = hi_age + AGE_W'(1);
        value_next = hi_value;
      end else if (lo_le) begin
        valid_next = 1'b1;
        age_next   = '0;
        value_next = ctrl.sample;
      end else begin
        valid_next = lo_valid;
        age_next   = lo_age + AGE_W'(1);
        value_next = lo_value;
      end
    end else if (hole_out) begin
      valid_next = above.good;
      age_next   = above.age;
      value_next = above.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    age   <= age_next;
    value <= value_next;
  end

  // neighbor view, status and median taps
  always_comb begin
    q.valid     = valid;
    q.age       = age;
    q.value     = value;
    q.le        = le_self;
    q.good      = good;
    stat.stale  = stale;
    stat.gap    = ~valid & above.valid;
    stat.full   = valid && ((LEN_W'(age) + LEN_W'(2)) == ctrl.len);
    tap_a_value = tap_a ? value : '0;
    tap_b_value = tap_b ? value : '0;
  end

endmodule

@@ rtl/swm_checker.sv @@
// port level checks of the sliding window median filter, bound to the top level
// depends on swm_pkg and assert_macros.svh
`include "assert_macros.svh"

module swm_assertions import swm_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [OUT_W-1:0]        median_doubled
);

  // a stalled result transaction holds its value
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(median_doubled), "result changed while stalled")

  // a new result needs an earlier input transaction, taken through the cell row and output register
  `ASSERT_CLK(a_out_cause, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a sample")

  // reset empties the output stage
  `ASSERT_CLK_RST(a_out_reset, $past(rst) |-> !out_valid, "result left after reset")

  // the length register takes every write
  `ASSERT_CLK(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind sliding_window_median swm_assertions u_swm_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .median_doubled (median_doubled)
);
